// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VROM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VROM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/vrom_pkg.sv =====
// ---------------------------------------------------------------------------
// vrom_pkg
// Widths, codes and shared types of the voxel ray occupancy marker.
// ---------------------------------------------------------------------------
package vrom_pkg;

  localparam int COORD_W = 19;  // signed coordinate, 1/640 m
  localparam int CELL_W  = 20;  // signed voxel coordinate
  localparam int SIZE_W  = 16;  // horizontal voxel edge
  localparam int LO_W    = 16;  // log-odds Q4.12
  localparam int NUM_W   = 29;  // crossing numerator
  localparam int DEN_W   = 20;  // crossing denominator
  localparam int PROD_W  = NUM_W + DEN_W;
  localparam int ZSHIFT  = 8;   // z voxels are 256 units tall
  localparam int IDX_W   = 20;
  localparam int CFG_W   = 19;
  localparam int CFGI_W  = 3;

  typedef logic [1:0] code_t;
  localparam code_t CODE_UNKNOWN = 2'd0;
  localparam code_t CODE_FREE    = 2'd1;
  localparam code_t CODE_OCC     = 2'd2;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_CAST  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [CFGI_W-1:0] CFG_SENSOR_X = 3'd0;
  localparam logic [CFGI_W-1:0] CFG_SENSOR_Y = 3'd1;
  localparam logic [CFGI_W-1:0] CFG_SENSOR_Z = 3'd2;
  localparam logic [CFGI_W-1:0] CFG_VOXEL    = 3'd3;
  localparam logic [CFGI_W-1:0] CFG_LO_OCC   = 3'd4;
  localparam logic [CFGI_W-1:0] CFG_LO_FREE  = 3'd5;

  // Floor quotient and floor remainder from the divider.
  typedef struct packed {
    logic [CELL_W-1:0] quot;
    logic [SIZE_W-1:0] rem;
  } div_res_t;

endpackage

// ===== design/voxel_ray_occupancy_marker_core.sv =====
// ---------------------------------------------------------------------------
// voxel_ray_occupancy_marker_core
// 3D voxel ray walker that marks free and occupied cells in a code memory.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | sink      | in_valid / in_stall  | action, point_x/y/z, cell_index
//  out     | source    | out_valid / out_stall| status, cell_code, cell_value
//  cfg     | sink      | cfg_we               | cfg_index, cfg_data
//
//  Cast: four serial divides, a setup step (S_INIT, plus S_DEC_RD and S_DEC_WR
//  when an axis descends), then per visited cell the products of crossing times
//  and then compare and write back; the grid memory's single read port sets the
//  per-cell pace. Read: one registered memory read. Clear: one cell per cycle,
//  CELLS_X*CELLS_Y*CELLS_Z cells. After reset a clearing pass over all cells runs
//  with in_stall high; configuration writes are taken throughout.
//  One request is worked on at a time; a finished result waits in the output
//  register while the next request is accepted.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module voxel_ray_occupancy_marker_core #(
  parameter int CELLS_X = 256,
  parameter int CELLS_Y = 256,
  parameter int CELLS_Z = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [vrom_pkg::CFGI_W-1:0]          cfg_index,
  input  logic [vrom_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           action,
  input  logic signed [vrom_pkg::COORD_W-1:0]  point_x,
  input  logic signed [vrom_pkg::COORD_W-1:0]  point_y,
  input  logic signed [vrom_pkg::COORD_W-1:0]  point_z,
  input  logic [vrom_pkg::IDX_W-1:0]           cell_index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 status,
  output logic [1:0]                           cell_code,
  output logic signed [vrom_pkg::LO_W-1:0]     cell_value
);
  import vrom_pkg::*;

  localparam longint unsigned TOTAL =
    longint'(CELLS_X) * longint'(CELLS_Y) * longint'(CELLS_Z);
  localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_DIV, S_INIT, S_DEC_RD, S_DEC_WR, S_MUL, S_STEP, S_FINISH
  } state_t;

  state_t state;

  // Configuration registers
  logic signed [COORD_W-1:0] sensor_x, sensor_y, sensor_z;
  logic [SIZE_W-1:0]         vox_edge;
  logic signed [LO_W-1:0]    lo_occ, lo_free;
  logic [SIZE_W-1:0]         vs;

  // Request and walk registers
  logic signed [COORD_W-1:0] px, py, pz;
  logic                      clr_reply;
  logic [AW-1:0]             clr_addr;
  logic [1:0]                div_sel;
  logic                      div_start;
  logic                      div_go;
  logic                      out_load;
  logic signed [CELL_W-1:0]  q_sx, q_px, q_sy, q_py;
  logic [SIZE_W-1:0]         r_sx, r_sy;
  logic signed [CELL_W-1:0]  cur  [3];
  logic signed [CELL_W-1:0]  endc [3];
  logic signed [CELL_W-1:0]  pend [3];
  logic                      dneg [3];
  logic [NUM_W-1:0]          num  [3];
  logic [DEN_W-1:0]          den  [3];
  logic [PROD_W-1:0]         p_l  [3];
  logic [PROD_W-1:0]         p_r  [3];
  logic                      res_status;
  code_t                     res_code;
  logic signed [LO_W-1:0]    res_value;

  // Divider
  logic signed [COORD_W-1:0] div_dvd;
  logic                      div_done;
  div_res_t                  div_res;

  // Memory ports
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  code_t                     mem_wdata;
  logic [AW-1:0]             mem_raddr;
  code_t                     mem_rdata;

  function automatic logic [AW-1:0] lin_addr(input logic signed [CELL_W-1:0] cx,
                                             input logic signed [CELL_W-1:0] cy,
                                             input logic signed [CELL_W-1:0] cz);
    lin_addr = AW'(cx[11:0]) +
               AW'(CELLS_X) * (AW'(cy[11:0]) + AW'(CELLS_Y) * AW'(cz[7:0]));
  endfunction

  function automatic logic in_lim(input logic signed [CELL_W-1:0] c, input int lim);
    in_lim = (c >= 0) && (c < $signed(CELL_W'(lim)));
  endfunction

  // Strictly later crossing of axis a than axis b; no motion is infinite.
  function automatic logic later(input logic inf_a, input logic inf_b,
                                 input logic [PROD_W-1:0] l,
                                 input logic [PROD_W-1:0] r);
    priority if (inf_a && inf_b) later = 1'b0;
    else if (inf_a)              later = 1'b1;
    else if (inf_b)              later = 1'b0;
    else                         later = (l > r);
  endfunction

  assign vs       = (vox_edge == '0) ? SIZE_W'(1) : vox_edge;
  assign in_stall = (state != S_IDLE);

  // Kick the divider on a cast request and after each of the first three divides.
  assign div_go   = ((state == S_IDLE) && in_valid && (action == ACT_CAST)) ||
                    ((state == S_DIV) && div_done && (div_sel != 2'd3));
  // Load the output register once the previous result has left or is leaving.
  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_x <= '0;
      sensor_y <= '0;
      sensor_z <= '0;
      vox_edge <= SIZE_W'(160);
      lo_occ   <= LO_W'(3470);
      lo_free  <= LO_W'(-1661);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SENSOR_X: sensor_x <= cfg_data;
        CFG_SENSOR_Y: sensor_y <= cfg_data;
        CFG_SENSOR_Z: sensor_z <= cfg_data;
        CFG_VOXEL:    vox_edge <= cfg_data[SIZE_W-1:0];
        CFG_LO_OCC:   lo_occ   <= cfg_data[LO_W-1:0];
        CFG_LO_FREE:  lo_free  <= cfg_data[LO_W-1:0];
        default: ;
      endcase
    end
  end

  // Divide sequence: sensor x, point x, sensor y, point y.
  always_comb begin
    unique case (div_sel)
      2'd0: div_dvd = sensor_x;
      2'd1: div_dvd = px;
      2'd2: div_dvd = sensor_y;
      default: div_dvd = py;
    endcase
  end

  vrom_floor_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (vs),
    .done     (div_done),
    .res      (div_res)
  );

  // Axis setup from the divide results; z uses a shift.
  logic signed [CELL_W-1:0]  i_c0 [3];
  logic signed [CELL_W-1:0]  i_e  [3];
  logic signed [COORD_W-1:0] i_p0 [3];
  logic signed [COORD_W-1:0] i_p1 [3];
  logic [SIZE_W:0]           i_r  [3];
  logic [SIZE_W:0]           i_sz [3];
  logic [SIZE_W:0]           i_sum [3];
  logic signed [CELL_W-1:0]  i_diff [3];
  logic                      i_neg [3];
  logic                      i_dec [3];
  logic                      any_dec;

  always_comb begin
    i_c0[0] = q_sx;  i_e[0] = q_px;  i_p0[0] = sensor_x; i_p1[0] = px;
    i_r[0]  = {1'b0, r_sx};          i_sz[0] = {1'b0, vs};
    i_c0[1] = q_sy;  i_e[1] = q_py;  i_p0[1] = sensor_y; i_p1[1] = py;
    i_r[1]  = {1'b0, r_sy};          i_sz[1] = {1'b0, vs};
    i_c0[2] = {{(ZSHIFT+1){sensor_z[COORD_W-1]}}, sensor_z[COORD_W-1:ZSHIFT]};
    i_e[2]  = {{(ZSHIFT+1){pz[COORD_W-1]}}, pz[COORD_W-1:ZSHIFT]};
    i_p0[2] = sensor_z; i_p1[2] = pz;
    i_r[2]  = (SIZE_W+1)'(sensor_z[ZSHIFT-1:0]);
    i_sz[2] = (SIZE_W+1)'(1 << ZSHIFT);
    any_dec = 1'b0;
    for (int i = 0; i < 3; i++) begin
      i_neg[i]  = (i_p1[i] < i_p0[i]);
      i_diff[i] = CELL_W'(i_p1[i]) - CELL_W'(i_p0[i]);
      i_sum[i]  = i_neg[i] ? (i_sz[i] + i_r[i]) : (i_sz[i] - i_r[i]);
      i_dec[i]  = (i_c0[i] != i_e[i]) && i_neg[i];
      any_dec   = any_dec | i_dec[i];
    end
  end

  // Step selection from the registered crossing products.
  logic                      all_end;
  logic                      inf [3];
  logic                      yx_gt, zx_gt, zy_gt;
  logic [1:0]                k;
  logic signed [CELL_W-1:0]  step_cell;
  logic                      step_out;
  logic [NUM_W-1:0]          inc_k;
  logic                      pend_in;
  logic [AW-1:0]             pend_addr;

  always_comb begin
    all_end = (cur[0] == endc[0]) && (cur[1] == endc[1]) && (cur[2] == endc[2]);
    for (int i = 0; i < 3; i++) begin
      inf[i] = (den[i] == '0);
    end
    yx_gt = later(inf[1], inf[0], p_l[0], p_r[0]);
    zx_gt = later(inf[2], inf[0], p_l[1], p_r[1]);
    zy_gt = later(inf[2], inf[1], p_l[2], p_r[2]);
    priority if (yx_gt && zx_gt)                k = 2'd0;
    else if ((yx_gt && !zx_gt) || !zy_gt)       k = 2'd2;
    else                                        k = 2'd1;
    step_cell = dneg[k] ? cur[k] - CELL_W'(1) : cur[k] + CELL_W'(1);
    unique case (k)
      2'd0:    step_out = !in_lim(step_cell, CELLS_X);
      2'd1:    step_out = !in_lim(step_cell, CELLS_Y);
      default: step_out = !in_lim(step_cell, CELLS_Z);
    endcase
    inc_k     = (k == 2'd2) ? NUM_W'(1 << ZSHIFT) : NUM_W'(vs);
    pend_in   = in_lim(pend[0], CELLS_X) && in_lim(pend[1], CELLS_Y) &&
                in_lim(pend[2], CELLS_Z);
    pend_addr = lin_addr(pend[0], pend[1], pend[2]);
  end

  // Read the pending cell, write it free unless occupied (occupied at the end).
  always_comb begin
    mem_raddr = (state == S_IDLE) ? AW'(cell_index) : pend_addr;
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = CODE_FREE;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = CODE_UNKNOWN;
      end
      S_DEC_WR: mem_we = pend_in && (mem_rdata != CODE_OCC);
      S_STEP: begin
        if (all_end) begin
          mem_we    = pend_in;
          mem_wdata = CODE_OCC;
        end else begin
          mem_we = pend_in && (mem_rdata != CODE_OCC);
        end
      end
      default: ;
    endcase
  end

  vrom_grid_mem #(
    .DEPTH (TOTAL),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_start <= div_go;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(TOTAL - 1)) begin
            state <= clr_reply ? S_FINISH : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            px         <= point_x;
            py         <= point_y;
            pz         <= point_z;
            res_status <= 1'b0;
            res_code   <= CODE_UNKNOWN;
            res_value  <= '0;
            unique case (action)
              ACT_CLEAR: begin
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              ACT_CAST: begin
                div_sel <= 2'd0;
                state   <= S_DIV;
              end
              ACT_READ: begin
                state <= (64'(cell_index) < TOTAL) ? S_RD : S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_RD: begin
          res_code <= mem_rdata;
          priority if (mem_rdata == CODE_FREE) res_value <= lo_free;
          else if (mem_rdata == CODE_OCC)      res_value <= lo_occ;
          else                                 res_value <= '0;
          state <= S_FINISH;
        end
        S_DIV: begin
          if (div_done) begin
            unique case (div_sel)
              2'd0: begin q_sx <= div_res.quot; r_sx <= div_res.rem; end
              2'd1: q_px <= div_res.quot;
              2'd2: begin q_sy <= div_res.quot; r_sy <= div_res.rem; end
              default: q_py <= div_res.quot;
            endcase
            if (div_sel == 2'd3) begin
              state <= S_INIT;
            end else begin
              div_sel <= div_sel + 2'd1;
            end
          end
        end
        S_INIT: begin
          // Step back the start cell on descending axes; mark the original first.
          for (int i = 0; i < 3; i++) begin
            cur[i]  <= i_dec[i] ? i_c0[i] - CELL_W'(1) : i_c0[i];
            endc[i] <= i_e[i];
            pend[i] <= i_c0[i];
            dneg[i] <= i_neg[i];
            den[i]  <= i_neg[i] ? DEN_W'(-i_diff[i]) : DEN_W'(i_diff[i]);
            num[i]  <= NUM_W'(i_sum[i]);
          end
          state <= any_dec ? S_DEC_RD : S_MUL;
        end
        S_DEC_RD: state <= S_DEC_WR;
        S_DEC_WR: begin
          for (int i = 0; i < 3; i++) begin
            pend[i] <= cur[i];
          end
          state <= S_MUL;
        end
        S_MUL: begin
          p_l[0] <= num[1] * den[0];
          p_r[0] <= num[0] * den[1];
          p_l[1] <= num[2] * den[0];
          p_r[1] <= num[0] * den[2];
          p_l[2] <= num[2] * den[1];
          p_r[2] <= num[1] * den[2];
          state  <= S_STEP;
        end
        S_STEP: begin
          priority if (all_end) begin
            state <= S_FINISH;
          end else if (step_out) begin
            // Left the grid: the last cell was freed, not occupied.
            res_status <= 1'b1;
            state      <= S_FINISH;
          end else begin
            cur[k] <= step_cell;
            num[k] <= num[k] + inc_k;
            for (int i = 0; i < 3; i++) begin
              pend[i] <= (k == 2'(i)) ? step_cell : cur[i];
            end
            state <= S_MUL;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            status     <= res_status;
            cell_code  <= res_code;
            cell_value <= res_value;
            clr_reply  <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `VROM_ASSERT_IMP(a_no_free_over_occ, clk, rst, mem_we && (mem_wdata == CODE_FREE), mem_rdata != CODE_OCC, "free written over an occupied cell")
  `VROM_ASSERT_NXT(a_accept_leaves_idle, clk, rst, in_valid && !in_stall, state != S_IDLE, "accepted request did not start work")
  `VROM_ASSERT_IMP(a_div_done_in_div, clk, rst, div_done, state == S_DIV, "divider finished outside the divide sequence")
  `VROM_ASSERT_IMP(a_result_from_finish, clk, rst, $rose(out_valid), $past(state) == S_FINISH, "result loaded outside finish")

endmodule

// ===== design/vrom_grid_mem.sv =====
// ---------------------------------------------------------------------------
// vrom_grid_mem
// Occupancy code memory: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module vrom_grid_mem #(
  parameter longint unsigned DEPTH = 1048576,
  parameter int              AW    = 20
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  vrom_pkg::code_t   wdata,
  input  logic [AW-1:0]     raddr,
  output vrom_pkg::code_t   rdata
);
  import vrom_pkg::*;

  code_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/vrom_floor_div.sv =====
// ---------------------------------------------------------------------------
// vrom_floor_div
// Radix-2 restoring divider: signed coordinate by voxel edge, floor rounding.
// ---------------------------------------------------------------------------
module vrom_floor_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [vrom_pkg::COORD_W-1:0]   dividend,
  input  logic [vrom_pkg::SIZE_W-1:0]           divisor,
  output logic                                  done,
  output vrom_pkg::div_res_t                    res
);
  import vrom_pkg::*;

  logic                busy;
  logic [4:0]          cnt;
  logic [COORD_W-1:0]  dvd;
  logic [SIZE_W-1:0]   acc;
  logic [SIZE_W-1:0]   dsr;
  logic                neg;
  logic [SIZE_W:0]     trial;
  logic                qbit;
  logic [SIZE_W-1:0]   acc_next;
  logic [CELL_W-1:0]   mag;

  always_comb begin
    trial    = {acc, dvd[COORD_W-1]};
    qbit     = (trial >= {1'b0, dsr});
    acc_next = qbit ? SIZE_W'(trial - {1'b0, dsr}) : trial[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == 5'd1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(COORD_W);
        neg  <= dividend[COORD_W-1];
        dvd  <= dividend[COORD_W-1] ? COORD_W'(-dividend) : dividend;
        acc  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        acc <= acc_next;
        dvd <= {dvd[COORD_W-2:0], qbit};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Fold the magnitude result back to floor semantics.
  always_comb begin
    mag = {1'b0, dvd};
    if (!neg) begin
      res.quot = mag;
      res.rem  = acc;
    end else if (acc == '0) begin
      res.quot = CELL_W'(-mag);
      res.rem  = '0;
    end else begin
      res.quot = CELL_W'(-mag - CELL_W'(1));
      res.rem  = dsr - acc;
    end
  end

endmodule

// ===== tb/tb_voxel_ray_occupancy_marker_core.sv =====
// ---------------------------------------------------------------------------
// tb_voxel_ray_occupancy_marker_core
// Self-checking bench for the voxel ray occupancy marker. A short table of
// hand-picked requests runs first. Random casts and reads follow, under five
// register settings that include the extremes. An in-bench model of the grid
// and of the ray walk predicts every result. Both channels idle at random.
// ---------------------------------------------------------------------------
module tb_voxel_ray_occupancy_marker_core;
  timeunit 1ns;
  timeprecision 1ps;
  import vrom_pkg::*;

  localparam int GX = 256;
  localparam int GY = 256;
  localparam int GZ = 16;
  localparam int ZVOX = 256;
  localparam int IDLE_LIMIT = 4000000;  // covers the reset clearing pass and one clear
  localparam logic [1:0] ACT_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFGI_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = ACT_CLEAR;
  logic signed [COORD_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic [IDX_W-1:0] cell_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic status;
  logic [1:0] cell_code;
  logic signed [LO_W-1:0] cell_value;

  voxel_ray_occupancy_marker_core #(.CELLS_X(GX), .CELLS_Y(GY), .CELLS_Z(GZ)) DUT (.*);

  always #5 clk = ~clk;

  typedef struct {
    logic st;
    logic [1:0] code;
    logic signed [LO_W-1:0] val;
  } cell_result_t;

  typedef struct {
    logic [1:0] act;
    int px, py, pz;
    int idx;
    bit typed;
    cell_result_t res;
  } req_row_t;

  cell_result_t pending_results[$];
  req_row_t directed[$];

  // Model copy of the registers and of the grid codes
  longint snr_x, snr_y, snr_z;
  longint unsigned vox;
  logic signed [LO_W-1:0] val_occ, val_free;
  logic [1:0] grid [0:GX*GY*GZ-1];
  int touched [0:63];
  int touch_ptr;

  int errors = 0;
  int n_cast = 0, n_exit = 0, n_read = 0, n_clear = 0;
  bit hold_req = 1'b0;
  bit calm = 1'b0;

  task automatic report(input string what, input int got, input int exp);
    errors++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, exp);
  endtask

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // Compare crossing times na/da and nb/db; a zero denominator is never.
  function automatic int cross_cmp(input longint unsigned na, da, nb, db);
    longint unsigned l, r;
    if (da == 0 && db == 0) return 0;
    if (da == 0) return 1;
    if (db == 0) return -1;
    l = na * db;
    r = nb * da;
    return (l > r) ? 1 : ((l < r) ? -1 : 0);
  endfunction

  function automatic void mark_cell(input longint c[3], input logic [1:0] code);
    int idx;
    if (c[0] < 0 || c[0] >= GX || c[1] < 0 || c[1] >= GY || c[2] < 0 || c[2] >= GZ)
      return;
    idx = int'(c[0] + GX * (c[1] + GY * c[2]));
    if (grid[idx] != CODE_OCC) grid[idx] = code;
    touched[touch_ptr] = idx;
    touch_ptr = (touch_ptr + 1) % 64;
  endfunction

  // Walk the ray from the sensor to (px,py,pz); return 1 if it leaves the grid.
  function automatic logic walk_ray(input longint px, py, pz);
    longint p0[3], p1[3], sz[3], lim[3], cur[3], endc[3], dir[3], pend[3];
    longint unsigned num[3], den[3];
    bit dec;
    int k, yx, zx, zy;
    p0 = '{snr_x, snr_y, snr_z};
    p1 = '{px, py, pz};
    sz = '{(vox == 0) ? 1 : longint'(vox), (vox == 0) ? 1 : longint'(vox), ZVOX};
    lim = '{GX, GY, GZ};
    dec = 1'b0;
    for (int i = 0; i < 3; i++) begin
      cur[i] = floor_div(p0[i], sz[i]);
      endc[i] = floor_div(p1[i], sz[i]);
      dir[i] = (p1[i] < p0[i]) ? -1 : 1;
      den[i] = (p1[i] < p0[i]) ? p0[i] - p1[i] : p1[i] - p0[i];
      num[i] = (dir[i] > 0) ? (cur[i] + 1) * sz[i] - p0[i] : p0[i] - (cur[i] - 1) * sz[i];
      pend[i] = cur[i];
    end
    // A descending axis first drops one cell below the start
    for (int i = 0; i < 3; i++)
      if (cur[i] != endc[i] && dir[i] < 0) begin
        cur[i]--;
        dec = 1'b1;
      end
    if (dec) begin
      mark_cell(pend, CODE_FREE);
      pend = cur;
    end
    while (!(cur[0] == endc[0] && cur[1] == endc[1] && cur[2] == endc[2])) begin
      yx = cross_cmp(num[1], den[1], num[0], den[0]);
      zx = cross_cmp(num[2], den[2], num[0], den[0]);
      zy = cross_cmp(num[2], den[2], num[1], den[1]);
      if (yx > 0 && zx > 0) k = 0;
      else if ((yx > 0 && zx <= 0) || zy <= 0) k = 2;
      else k = 1;
      cur[k] += dir[k];
      if (cur[k] < 0 || cur[k] >= lim[k]) begin
        mark_cell(pend, CODE_FREE);
        return 1'b1;
      end
      num[k] += sz[k];
      mark_cell(pend, CODE_FREE);
      pend = cur;
    end
    mark_cell(pend, CODE_OCC);
    return 1'b0;
  endfunction

  // Apply one accepted request to the model and return its result.
  function automatic cell_result_t predict_cell_result(input logic [1:0] act,
      input logic signed [COORD_W-1:0] px, py, pz, input logic [IDX_W-1:0] idx);
    cell_result_t r;
    r = '{1'b0, CODE_UNKNOWN, '0};
    case (act)
      ACT_CLEAR: begin
        foreach (grid[i]) grid[i] = CODE_UNKNOWN;
        n_clear++;
      end
      ACT_CAST: begin
        r.st = walk_ray(px, py, pz);
        n_cast++;
        if (r.st) n_exit++;
      end
      ACT_READ: begin
        r.code = grid[idx];
        if (r.code == CODE_FREE) r.val = val_free;
        else if (r.code == CODE_OCC) r.val = val_occ;
        n_read++;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic write_reg(input logic [CFGI_W-1:0] idx, input longint v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v[CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_SENSOR_X: snr_x = v;
      CFG_SENSOR_Y: snr_y = v;
      CFG_SENSOR_Z: snr_z = v;
      CFG_VOXEL:    vox = longint'(v[SIZE_W-1:0]);
      CFG_LO_OCC:   val_occ = v[LO_W-1:0];
      CFG_LO_FREE:  val_free = v[LO_W-1:0];
      default: ;
    endcase
  endtask

  // Drain, let the block settle, then load all six registers.
  task automatic load_setting(input longint sx, sy, sz, vs, lo_o, lo_f);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    write_reg(CFG_SENSOR_X, sx);
    write_reg(CFG_SENSOR_Y, sy);
    write_reg(CFG_SENSOR_Z, sz);
    write_reg(CFG_VOXEL, vs);
    write_reg(CFG_LO_OCC, lo_o);
    write_reg(CFG_LO_FREE, lo_f);
  endtask

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input logic [1:0] act, input logic signed [COORD_W-1:0] px,
      py, pz, input logic [IDX_W-1:0] idx, input bit typed, input cell_result_t typed_res);
    int gap;
    cell_result_t r;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    action = act;
    point_x = px;
    point_y = py;
    point_z = pz;
    cell_index = idx;
    do @(posedge clk); while (in_stall);
    r = predict_cell_result(act, px, py, pz, idx);
    pending_results.insert(pending_results.size(), typed ? typed_res : r);
    @(negedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] near(input longint c, input longint span);
    longint off;
    off = longint'($urandom_range(0, 32'(2 * span))) - span;
    return COORD_W'(c + off);
  endfunction

  // Mostly casts near the sensor, reads of recently marked cells, some noise.
  task automatic random_requests(input int count);
    int pick;
    longint span;
    logic [IDX_W-1:0] idx;
    logic signed [COORD_W-1:0] px, py, pz;
    span = (vox == 0) ? 6 : 6 * longint'(vox);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      px = COORD_W'($urandom);
      py = COORD_W'($urandom);
      pz = COORD_W'($urandom);
      idx = IDX_W'($urandom);
      if (pick < 55) begin
        if ($urandom_range(0, 19) != 0) begin
          px = near(snr_x, span);
          py = near(snr_y, span);
          pz = near(snr_z, 1500);
        end
        send_request(ACT_CAST, px, py, pz, idx, 1'b0, '{0, 0, 0});
      end else if (pick < 98) begin
        if ($urandom_range(0, 9) < 6) idx = IDX_W'(touched[$urandom_range(0, 63)]);
        send_request(ACT_READ, px, py, pz, idx, 1'b0, '{0, 0, 0});
      end else begin
        send_request(ACT_NONE, px, py, pz, idx, 1'b0, '{0, 0, 0});
      end
    end
    in_valid = 1'b0;
  endtask

  // Result side: random stalls per result, one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      n = calm ? 0 : $urandom_range(0, 3);
      out_stall = (n != 0);
      if (n != 0) repeat (n) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    cell_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st) report("status", int'(status), int'(e.st));
        if (cell_code !== e.code) report("cell_code", int'(cell_code), int'(e.code));
        if (cell_value !== e.val) report("cell_value", int'(cell_value), int'(e.val));
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves anything.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("tb_voxel_ray_occupancy_marker_core: errors");
        $finish;
      end
    end
  end

  initial begin
    req_row_t row;
    foreach (grid[i]) grid[i] = CODE_UNKNOWN;
    foreach (touched[i]) touched[i] = 0;
    touch_ptr = 0;
    snr_x = 0; snr_y = 0; snr_z = 0;
    vox = 160;
    val_occ = 3470;
    val_free = -1661;

    // Sensor cell is (125,125,7), index 490877.
    directed.push_back('{ACT_READ, 0, 0, 0, 0, 1, '{0, CODE_UNKNOWN, 0}});
    directed.push_back('{ACT_READ, 0, 0, 0, 20'hFFFFF, 1, '{0, CODE_UNKNOWN, 0}});
    directed.push_back('{ACT_NONE, -1, -1, -1, 20'hFFFFF, 1, '{0, CODE_UNKNOWN, 0}});
    directed.push_back('{ACT_CAST, 20000, 20000, 2000, 0, 1, '{0, CODE_UNKNOWN, 0}});
    directed.push_back('{ACT_READ, 0, 0, 0, 490877, 1, '{0, CODE_OCC, 3470}});
    directed.push_back('{ACT_CAST, 21000, 19000, 2600, 0, 0, '{0, 0, 0}});
    directed.push_back('{ACT_CAST, 262143, 262143, 262143, 0, 1, '{1, CODE_UNKNOWN, 0}});
    directed.push_back('{ACT_CAST, -262144, -262144, -262144, 0, 1, '{1, CODE_UNKNOWN, 0}});
    directed.push_back('{ACT_CAST, 19900, 20000, 2000, 0, 0, '{0, 0, 0}});
    directed.push_back('{ACT_CAST, 19000, 21500, 1700, 0, 0, '{0, 0, 0}});
    directed.push_back('{ACT_READ, 0, 0, 0, 490876, 0, '{0, 0, 0}});
    directed.push_back('{ACT_READ, 0, 0, 0, 490878, 0, '{0, 0, 0}});
    directed.push_back('{ACT_CLEAR, 0, 0, 0, 0, 1, '{0, CODE_UNKNOWN, 0}});
    directed.push_back('{ACT_READ, 0, 0, 0, 490877, 1, '{0, CODE_UNKNOWN, 0}});
    directed.push_back('{ACT_CAST, 20100, 20100, 1800, 0, 0, '{0, 0, 0}});
    directed.push_back('{ACT_READ, 0, 0, 0, 490877, 0, '{0, 0, 0}});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    load_setting(20000, 20000, 2000, 160, 3470, -1661);
    foreach (directed[i]) begin
      row = directed[i];
      send_request(row.act, COORD_W'(row.px), COORD_W'(row.py), COORD_W'(row.pz),
                   IDX_W'(row.idx), row.typed, row.res);
    end
    in_valid = 1'b0;
    random_requests(200);

    // Zero voxel size behaves as one unit; log-odds at the extremes
    load_setting(128, 100, 1000, 0, 32767, -32768);
    random_requests(200);

    // Sensor far outside the grid, widest voxels
    load_setting(-262144, 262143, -262144, 65535, -32768, 32767);
    random_requests(60);

    load_setting(200, 50, 3900, 1, 100, -100);
    random_requests(200);

    // Hold off the result side early so the block backs up its input
    load_setting(40000, 1000, 100, 300, -7, 7);
    fork
      begin
        repeat (20) @(posedge clk);
        hold_req = 1'b1;
      end
      random_requests(340);
    join

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d casts (%0d left the grid), %0d reads, %0d clears",
             n_cast, n_exit, n_read, n_clear);
    $display("over five register settings with random idling on both sides");
    if (errors == 0) begin
      $display("tb_voxel_ray_occupancy_marker_core: clean");
    end else begin
      $display("tb_voxel_ray_occupancy_marker_core: errors");
    end
    $finish;
  end

endmodule
